### hdl/ptast_pkg.sv
// ----------------------------------------------------------------------------
// ptast_pkg
// shared types and codes for the port-to-application sorted table
// ----------------------------------------------------------------------------
package ptast_pkg;

   localparam int DEPTH_DEFAULT = 64;

   // request operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   // token modes travelling down the cell chain
   localparam logic [1:0] MODE_LOOKUP = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;   // insert into a full table

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic        func;
      logic [15:0] port;
      logic [7:0]  app_id;
   } req_type;

   typedef struct packed {
      logic       found;
      logic [7:0] app_out;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [1:0]  mode;
      logic [15:0] key;
      logic [7:0]  id;
      logic        hit;
      logic        done;
      logic        added;
   } token_type;

endpackage

### hdl/ptast_cell.sv
// ----------------------------------------------------------------------------
// ptast_cell
// one table slot plus the token register that feeds the next slot
// ----------------------------------------------------------------------------
module ptast_cell
   import ptast_pkg::*;
#(
   parameter int CW  = 7,
   parameter int IDX = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  token_type       tok_prev,
   input  logic [CW-1:0]   count,
   output token_type       tok_next
);

   logic [15:0] key_ff, key_in;
   logic [7:0]  id_ff, id_in;
   token_type   pass_ff, pass_in;
   logic        entry_valid;
   logic        eq;
   logic        less;

   // slot holds data when its index is below the fill count
   assign entry_valid = count > CW'(IDX);
   assign eq          = entry_valid && (key_ff == tok_prev.key);
   assign less        = entry_valid && (key_ff < tok_prev.key);

   always_comb begin
      key_in  = key_ff;
      id_in   = id_ff;
      pass_in = tok_prev;
      if (tok_prev.valid && !tok_prev.done) begin
         unique case (tok_prev.mode)
            MODE_LOOKUP: begin
               if (eq) begin
                  pass_in.hit  = 1'b1;
                  pass_in.id   = id_ff;
                  pass_in.done = 1'b1;
               end
            end
            MODE_UPDATE: begin
               if (eq) begin
                  id_in        = tok_prev.id;
                  pass_in.hit  = 1'b1;
                  pass_in.done = 1'b1;
               end
            end
            MODE_INSERT: begin
               if (eq) begin
                  id_in        = tok_prev.id;
                  pass_in.done = 1'b1;
               end else if (!entry_valid) begin
                  // first free slot takes the carried entry
                  key_in        = tok_prev.key;
                  id_in         = tok_prev.id;
                  pass_in.done  = 1'b1;
                  pass_in.added = 1'b1;
               end else if (!less) begin
                  // swap: larger entry moves one slot on
                  key_in       = tok_prev.key;
                  id_in        = tok_prev.id;
                  pass_in.key  = key_ff;
                  pass_in.id   = id_ff;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff <= '0;
      end else begin
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      id_ff  <= id_in;
   end

   assign tok_next = pass_ff;

endmodule

### hdl/port_to_app_sorted_table_core.sv
// ----------------------------------------------------------------------------
// port_to_app_sorted_table_core
// sorted port-to-application table built as a chain of slot cells
// ----------------------------------------------------------------------------
// one request in flight at a time; its token walks the whole cell chain,
//    one cell per cycle, into the holding register and then into the output
//    register that drives rsp_valid
// a waiting response does not block the next request
// reset: synchronous, clears fill count, tokens and handshake state; slot
//    contents are not cleared
// ----------------------------------------------------------------------------
module port_to_app_sorted_table_core
   import ptast_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] count_ff, count_in;
   token_type     head_ff, head_in;
   logic          fin_valid_ff, fin_valid_in;
   rsp_type       fin_data_ff, fin_data_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic          accept;
   logic          move;
   logic          full;
   token_type     tok [0:DEPTH];
   token_type     tok_last;

   // one request in flight at a time
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CW'(DEPTH));

   // build the token; insert keys are byte swapped to network order
   always_comb begin
      head_in       = '0;
      head_in.valid = accept;
      head_in.id    = req_data.app_id;
      if (req_data.func == FUNC_LOOKUP) begin
         head_in.mode = MODE_LOOKUP;
         head_in.key  = req_data.port;
      end else begin
         head_in.mode = full ? MODE_UPDATE : MODE_INSERT;
         head_in.key  = {req_data.port[7:0], req_data.port[15:8]};
      end
   end

   assign tok[0] = head_ff;

   // the slot chain: each cell sees the token in the cycle after its neighbour
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ptast_cell #(
         .CW  (CW),
         .IDX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .tok_prev (tok[i]),
         .count    (count_ff),
         .tok_next (tok[i+1])
      );
   end

   assign tok_last = tok[DEPTH];

   // finished token becomes a response word in the holding register
   always_comb begin
      fin_valid_in = fin_valid_ff;
      fin_data_in  = fin_data_ff;
      count_in     = count_ff;
      if (tok_last.valid) begin
         fin_valid_in        = 1'b1;
         fin_data_in.found   = (tok_last.mode == MODE_LOOKUP) && tok_last.hit;
         fin_data_in.app_out = fin_data_in.found ? tok_last.id : 8'd0;
         fin_data_in.status  = ((tok_last.mode == MODE_UPDATE) && !tok_last.hit) ?
                               STATUS_FULL : STATUS_OK;
         count_in            = count_ff + CW'(tok_last.added);
      end else if (move) begin
         fin_valid_in = 1'b0;
      end
   end

   // holding register to output register
   assign move = fin_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (move) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload only
   always_ff @(posedge clock) begin
      fin_data_ff <= fin_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hdl/ptast_checker.sv
// ----------------------------------------------------------------------------
// ptast_checker
// port-level checks for the sorted table, bound to the top level
// ----------------------------------------------------------------------------
module ptast_checker
   import ptast_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response word changed while stalled");

   // only one request in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a refused insert never reports a hit
   a_full_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL) |-> !rsp_data.found)
      else $error("full status with found set");

   // a miss carries a zero identifier
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.app_out == 8'd0)
      else $error("non-zero identifier on a miss");

endmodule

bind port_to_app_sorted_table_core ptast_checker u_ptast_checker (.*);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the port-to-application sorted table core:
// a short table of directed words, then random insert and lookup words
// biased towards hits, duplicates and a full table, each response compared
// field by field against the known answer or a shadow copy of the sorted table
// ----------------------------------------------------------------------------
module testbench
   import ptast_pkg::*;
();

   localparam int TABLE_DEPTH  = DEPTH_DEFAULT;
   localparam int HALF_PERIOD  = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_WORDS = 830;
   // random part phases: light idling, none, heavy idling, then quiet to the end
   localparam int CALM_FROM    = 280;
   localparam int BUSY_FROM    = 500;
   localparam int QUIET_FROM   = 730;

   // response of any insert that went in, and of any lookup miss
   localparam rsp_type RSP_PLAIN = '{found: 1'b0, app_out: 8'h00, status: STATUS_OK};

   typedef struct {
      req_type word;
      bit      typed;    // response below is known by inspection
      rsp_type result;
   } directed_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow of the table contents, keys in network order, ascending
   logic [15:0] shadow_keys [TABLE_DEPTH];
   logic [7:0]  shadow_ids  [TABLE_DEPTH];
   int          shadow_fill = 0;

   rsp_type pending_results [$];
   int      error_count    = 0;
   int      cycle_count    = 0;
   int      idle_pct       = 0;
   int      rsp_stall_left = 0;

   // directed words: empty table, extreme ports and ids, byte order,
   // duplicate overwrite and keys that differ only in byte order
   directed_row_type directed_rows [22] = '{
      '{'{FUNC_LOOKUP, 16'h0000, 8'hFF}, 1'b1, RSP_PLAIN},   // empty table miss
      '{'{FUNC_LOOKUP, 16'hFFFF, 8'h00}, 1'b1, RSP_PLAIN},
      '{'{FUNC_INSERT, 16'h0000, 8'h00}, 1'b1, RSP_PLAIN},
      '{'{FUNC_INSERT, 16'hFFFF, 8'hFF}, 1'b1, RSP_PLAIN},
      '{'{FUNC_INSERT, 16'h1234, 8'hA5}, 1'b1, RSP_PLAIN},
      '{'{FUNC_LOOKUP, 16'h3412, 8'h00}, 1'b1, '{1'b1, 8'hA5, STATUS_OK}},
      '{'{FUNC_LOOKUP, 16'h1234, 8'h00}, 1'b1, RSP_PLAIN},   // host order misses
      '{'{FUNC_LOOKUP, 16'h0000, 8'hAA}, 1'b1, '{1'b1, 8'h00, STATUS_OK}},
      '{'{FUNC_LOOKUP, 16'hFFFF, 8'h55}, 1'b1, '{1'b1, 8'hFF, STATUS_OK}},
      '{'{FUNC_INSERT, 16'h1234, 8'h5A}, 1'b1, RSP_PLAIN},   // overwrite
      '{'{FUNC_LOOKUP, 16'h3412, 8'h00}, 1'b1, '{1'b1, 8'h5A, STATUS_OK}},
      '{'{FUNC_INSERT, 16'h0001, 8'h11}, 1'b0, '0},
      '{'{FUNC_INSERT, 16'h0100, 8'h22}, 1'b0, '0},
      '{'{FUNC_INSERT, 16'hFF00, 8'h33}, 1'b0, '0},
      '{'{FUNC_INSERT, 16'h8000, 8'h80}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'h0100, 8'h00}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'h0001, 8'h00}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'h00FF, 8'h00}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'h0080, 8'h00}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'h0002, 8'h00}, 1'b0, '0},
      '{'{FUNC_LOOKUP, 16'hFFFE, 8'h00}, 1'b0, '0},
      '{'{FUNC_INSERT, 16'h7F7F, 8'h7F}, 1'b0, '0}
   };

   port_to_app_sorted_table_core #(
      .DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic logic [15:0] swap_bytes(logic [15:0] port);
      return {port[7:0], port[15:8]};
   endfunction

   // first slot whose key is not below the given one
   function automatic int first_not_below(logic [15:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = shadow_fill;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (shadow_keys[mid] < key) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   // applies one word to the shadow table and returns the response it earns
   function automatic rsp_type table_answer(req_type word);
      rsp_type     answer;
      logic [15:0] key;
      int          pos;
      answer = RSP_PLAIN;
      // inserts arrive in host order, the table holds network order
      key = (word.func == FUNC_INSERT) ? swap_bytes(word.port) : word.port;
      pos = first_not_below(key);
      if (word.func == FUNC_LOOKUP) begin
         if (pos < shadow_fill && shadow_keys[pos] == key) begin
            answer.found   = 1'b1;
            answer.app_out = shadow_ids[pos];
         end
      end else if (pos < shadow_fill && shadow_keys[pos] == key) begin
         // known key: new id, even when the table is full
         shadow_ids[pos] = word.app_id;
      end else if (shadow_fill >= TABLE_DEPTH) begin
         answer.status = STATUS_FULL;
      end else begin
         for (int i = shadow_fill; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i - 1];
            shadow_ids[i]  = shadow_ids[i - 1];
         end
         shadow_keys[pos] = key;
         shadow_ids[pos]  = word.app_id;
         shadow_fill++;
      end
      return answer;
   endfunction

   // random word, leaning on keys the table already holds
   function automatic req_type random_word();
      req_type word;
      int      roll;
      int      idx;
      word.func   = ($urandom_range(0, 1) == 1) ? FUNC_LOOKUP : FUNC_INSERT;
      word.port   = 16'($urandom);
      word.app_id = 8'($urandom);
      roll        = $urandom_range(0, 99);
      if (shadow_fill > 0) begin
         idx = $urandom_range(0, shadow_fill - 1);
         if (word.func == FUNC_LOOKUP) begin
            if (roll < 55) word.port = shadow_keys[idx];
            // near miss just beside a stored key
            else if (roll < 70) word.port = shadow_keys[idx] + (roll[0] ? 16'h0001 : 16'hFFFF);
         end else if (roll < 40) begin
            word.port = swap_bytes(shadow_keys[idx]);
         end
      end
      return word;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // called at a falling edge; leaves valid high at the falling edge after acceptance
   task automatic send_word(req_type word, bit typed, rsp_type typed_result);
      rsp_type answer;
      req_data  <= word;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      answer = table_answer(word);
      pending_results.push_back(typed ? typed_result : answer);
      @(negedge clock);
   endtask

   // sender idling burst
   task automatic sender_gap();
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   // hold off the sender until every pending response has arrived
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   // response side: ready stalls in bursts, driven at the falling edge
   always @(negedge clock) begin
      if (reset || idle_pct == 0) begin
         rsp_ready      <= 1'b1;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if ($urandom_range(0, 99) < idle_pct) begin
         rsp_ready      <= 1'b0;
         rsp_stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker, sampled at the rising edge
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("response word %h with nothing pending", rsp_data));
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.found !== want.found)
               report_mismatch($sformatf("found %b, want %b", rsp_data.found, want.found));
            if (rsp_data.app_out !== want.app_out)
               report_mismatch($sformatf("app_out %h, want %h", rsp_data.app_out,
                                         want.app_out));
            if (rsp_data.status !== want.status)
               report_mismatch($sformatf("status %b, want %b", rsp_data.status, want.status));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[port_to_app_sorted_table_core] ERROR");
      $finish;
   end

   // stimulus
   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset    <= 1'b0;
      idle_pct = 20;

      foreach (directed_rows[i]) begin
         sender_gap();
         send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
      end

      // the table fills part-way through, after which new keys are refused
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == CALM_FROM || n == BUSY_FROM || n == QUIET_FROM) wait_for_drain();
         if (n < CALM_FROM) idle_pct = 25;
         else if (n < BUSY_FROM) idle_pct = 0;
         else if (n < QUIET_FROM) idle_pct = 40;
         else idle_pct = 0;
         sender_gap();
         send_word(random_word(), 1'b0, RSP_PLAIN);
      end

      wait_for_drain();
      // let anything stray fall out of the cell chain
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("[port_to_app_sorted_table_core] OK");
      end else begin
         $display("[port_to_app_sorted_table_core] ERROR");
      end
      $finish;
   end

endmodule
